FILE: src/assert_macros.svh
// Assertion macros shared by the determinant block.
// Each macro compiles to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: src/idet_pkg.sv
// Package for the integer determinant block: sizes, widths and types.
// Used by idet_engine and integer_determinant_top; depends on nothing.
`default_nettype none
package idet_pkg;
  localparam int MaxSize = 8;
  localparam int ElemW = 16;
  localparam int DetW = 64;
  localparam int SizeW = 4;
  localparam int IdxW = $clog2(MaxSize);
  localparam int StoreDepth = MaxSize * MaxSize;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam int SubsetCount = 1 << MaxSize;
  localparam int CntW = $clog2(StoreDepth + 1);

  typedef struct packed {
    logic         start;
    logic [IdxW:0] n;
  } idet_start_t;

  typedef struct packed {
    logic          done;
    logic [DetW-1:0] det;
  } idet_done_t;
endpackage
`default_nettype wire

FILE: src/idet_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module idet_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/idet_engine.sv
// Subset-minor engine: walks column subsets, one term per step, with
// the matrix and minor tables in RAM. Depends on idet_pkg, idet_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module idet_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire idet_pkg::idet_start_t         ctl,
  input  wire logic                          ld_we,
  input  wire logic [idet_pkg::StoreAw-1:0]  ld_addr,
  input  wire logic [idet_pkg::ElemW-1:0]    ld_data,
  output idet_pkg::idet_done_t               stat,
  output logic                               busy
);
  localparam int MW = idet_pkg::MaxSize;
  localparam int DW = idet_pkg::DetW;
  localparam int EW = idet_pkg::ElemW;

  typedef enum logic [2:0] {S_IDLE, S_MASK, S_FETCH, S_MUL, S_ACC, S_WRITE} st_t;
  st_t st_r;

  logic [idet_pkg::IdxW:0] n_r;
  logic [MW-1:0] mask_r, full_r;
  logic [idet_pkg::IdxW-1:0] col_r, row_r;
  logic [DW-1:0] acc_r, prod_r;
  logic neg_r, neg_p_r;
  logic [DW-1:0] sub_wdata, sub_rdata;
  logic sub_we;
  logic [MW-1:0] sub_waddr, sub_raddr;
  logic [EW-1:0] m_rdata;
  logic [idet_pkg::StoreAw-1:0] m_raddr;
  logic [MW-1:0] bit_c;
  logic [idet_pkg::IdxW:0] pop_mask, pop_low;

  always_comb begin
    pop_mask = '0;
    pop_low = '0;
    for (int i = 0; i < MW; i++) begin
      pop_mask = pop_mask + (idet_pkg::IdxW+1)'(mask_r[i]);
      if (i < 32'(col_r)) pop_low = pop_low + (idet_pkg::IdxW+1)'(mask_r[i]);
    end
  end

  assign bit_c = MW'(1) << col_r;
  // Matrix address row*n+col; elements load packed row-major, so row*MaxSize+col matches
  // only when n equals MaxSize, so compute the row-major index explicitly.
  assign m_raddr = idet_pkg::StoreAw'(32'(row_r) * 32'(n_r) + 32'(col_r));
  assign sub_raddr = mask_r & ~bit_c;
  assign sub_we = (st_r == S_WRITE) || (st_r == S_IDLE && ctl.start);
  assign sub_waddr = (st_r == S_IDLE) ? '0 : mask_r;
  assign sub_wdata = (st_r == S_IDLE) ? DW'(1) : acc_r;

  idet_ram #(.Width(EW), .Depth(idet_pkg::StoreDepth)) u_mat (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(ld_data),
    .raddr(m_raddr), .rdata(m_rdata));

  idet_ram #(.Width(DW), .Depth(idet_pkg::SubsetCount)) u_sub (
    .clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wdata),
    .raddr(sub_raddr), .rdata(sub_rdata));

  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (ctl.start) begin
          n_r <= ctl.n;
          full_r <= MW'((1 << ctl.n) - 1);
          mask_r <= MW'(1);
          st_r <= S_MASK;
        end
        S_MASK: begin
          // Minors of the lower rows; row depends on subset size.
          row_r <= idet_pkg::IdxW'(n_r - pop_mask);
          col_r <= '0;
          acc_r <= '0;
          st_r <= S_FETCH;
        end
        S_FETCH: begin
          if (mask_r[col_r]) begin
            neg_r <= pop_low[0];
            st_r <= S_MUL;
          end else if (32'(col_r) == 32'(n_r) - 1) begin
            st_r <= S_WRITE;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r <= DW'(signed'(m_rdata) * signed'({1'b0, sub_rdata[31:0]}))
                  + (DW'(signed'(m_rdata) * signed'({1'b0, sub_rdata[DW-1:32]})) << 32);
          neg_p_r <= neg_r;
          st_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= neg_p_r ? acc_r - prod_r : acc_r + prod_r;
          if (32'(col_r) == 32'(n_r) - 1) st_r <= S_WRITE;
          else begin
            col_r <= col_r + 1'b1;
            st_r <= S_FETCH;
          end
        end
        S_WRITE: begin
          if (mask_r == full_r) begin
            stat.done <= 1'b1;
            stat.det <= acc_r;
            st_r <= S_IDLE;
          end else begin
            mask_r <= mask_r + 1'b1;
            st_r <= S_MASK;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_done_from_write, stat.done |-> $past(st_r == S_WRITE), "done without write")
  `ASSERT_NEVER(a_start_busy, ctl.start && busy, "start while busy")
  `ASSERT_CLK(a_mul_after_fetch, (st_r == S_MUL) |-> $past(st_r == S_FETCH), "bad mul entry")
endmodule
`default_nettype wire

FILE: src/integer_determinant_top.sv
// Determinant block: elements load one per cycle; after the last one the engine
// walks the 2^n - 1 column subsets (n = size clamped to 1..8), giving each column
// a fetch step and each member column a multiply and an accumulate step; the result
// then passes from the engine's done register into the output register.
// Input is held off from the last element until the result is taken.
// Synchronous active-low reset clears control; size returns to 3.
`default_nettype none
module integer_determinant_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [idet_pkg::SizeW-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [idet_pkg::ElemW-1:0] in_element_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [idet_pkg::DetW-1:0] out_determinant
);
  logic [idet_pkg::SizeW-1:0] size_r;
  logic [idet_pkg::CntW-1:0] cnt_r;
  logic [idet_pkg::IdxW:0] n_eff;
  logic [idet_pkg::CntW-1:0] total;
  logic busy, acc_in, last;
  logic start_r;
  idet_pkg::idet_start_t ctl;
  idet_pkg::idet_done_t stat;

  always_comb begin
    if (size_r == '0) n_eff = (idet_pkg::IdxW+1)'(1);
    else if (32'(size_r) > idet_pkg::MaxSize) n_eff = (idet_pkg::IdxW+1)'(idet_pkg::MaxSize);
    else n_eff = (idet_pkg::IdxW+1)'(size_r);
  end
  assign total = idet_pkg::CntW'(32'(n_eff) * 32'(n_eff));
  // A result leaving the engine must reach the output register before new loads.
  assign in_ready = !busy && !out_valid && !start_r && !stat.done;
  assign acc_in = in_valid && in_ready;
  assign last = (cnt_r + 1'b1) == total;
  assign ctl = '{start: start_r, n: n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= idet_pkg::SizeW'(3);
      cnt_r <= '0;
      start_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_r <= acc_in && last;
      if (cfg_we) begin
        size_r <= cfg_wdata;
        cnt_r <= '0;
      end else if (acc_in) cnt_r <= last ? '0 : cnt_r + 1'b1;
      if (stat.done) begin
        out_valid <= 1'b1;
        out_determinant <= stat.det;
      end else if (out_ready) out_valid <= 1'b0;
    end
  end

  idet_engine u_eng (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .ld_we(acc_in), .ld_addr(idet_pkg::StoreAw'(cnt_r)), .ld_data(in_element_value),
    .stat(stat), .busy(busy));
endmodule
`default_nettype wire
